[rtl/adam_weight_update_defines.svh]
// Assertion macros used by the top-level RTL file.
`ifndef ADAM_WEIGHT_UPDATE_DEFINES_SVH
`define ADAM_WEIGHT_UPDATE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define AWU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("adam_weight_update: same-cycle check failed");
`define AWU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("adam_weight_update: next-cycle check failed");
`else
`define AWU_ASSERT_NOW(label, clk, rst, ante, cons)
`define AWU_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/adwu_pkg.sv]
`default_nettype none
package adwu_pkg;

   localparam int unsigned MAX_LENGTH_DEF = 1024;

   localparam int DATA_W      = 32;
   localparam int INDEX_W     = 10;
   localparam int VLEN_W      = 11;
   localparam int COEF_W      = 24;
   localparam int EPS_W       = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_NUM_W   = 64;
   localparam int DIV_DEN_W   = 40;

   // 1.0 in Q1.24
   localparam logic [COEF_W:0] Q_ONE = 25'h100_0000;

   localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] SAT_MIN = -32'sh7FFF_FFFF - 32'sd1;

   localparam logic [VLEN_W-1:0] VECTOR_LENGTH_RST = 11'd1024;
   localparam logic [COEF_W-1:0] STEP_SIZE_RST     = 24'd16777;
   localparam logic [COEF_W-1:0] BETA_FIRST_RST    = 24'd15099494;
   localparam logic [COEF_W-1:0] BETA_SECOND_RST   = 24'd16760439;
   localparam logic [EPS_W-1:0]  EPSILON_TERM_RST  = 32'd43;

   localparam logic OP_LOAD     = 1'b0;
   localparam logic OP_GRADIENT = 1'b1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_VECTOR_LENGTH = 3'd0,
      CSR_STEP_SIZE     = 3'd1,
      CSR_BETA_FIRST    = 3'd2,
      CSR_BETA_SECOND   = 3'd3,
      CSR_EPSILON_TERM  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [VLEN_W-1:0] vector_length;
      logic [COEF_W-1:0] step_size;
      logic [COEF_W-1:0] beta_first;
      logic [COEF_W-1:0] beta_second;
      logic [EPS_W-1:0]  epsilon_term;
   } adwu_cfg_type;

   typedef struct packed {
      logic                     op;
      logic [INDEX_W-1:0]       index;
      logic signed [DATA_W-1:0] value;
      logic                     last;
      logic                     bad;
   } adwu_item_type;

endpackage
`default_nettype wire

[rtl/adwu_ram.sv]
`default_nettype none
module adwu_ram #(
   parameter int WIDTH  = 32,
   parameter int DEPTH  = 1024,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[rtl/adwu_front.sv]
`default_nettype none
module adwu_front #(
   parameter int unsigned MAX_LENGTH = adwu_pkg::MAX_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              clearing,
   input  logic [adwu_pkg::VLEN_W-1:0]       vector_length,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_op,
   input  logic [adwu_pkg::INDEX_W-1:0]      req_index,
   input  logic signed [adwu_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              item_valid,
   output adwu_pkg::adwu_item_type           item,
   input  logic                              item_pop
);
   import adwu_pkg::*;

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   adwu_item_type    slot_ff [QUEUE_DEPTH];
   adwu_item_type    new_item;
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             push;
   logic             pop;

   always_comb begin
      new_item.op    = req_op;
      new_item.index = req_index;
      new_item.value = req_value;
      new_item.last  = req_last;
      // Out-of-range items still travel through the queue to keep order.
      new_item.bad   = ({1'b0, req_index} >= vector_length) ||
                       (32'(req_index) >= 32'(MAX_LENGTH));
   end

   assign req_ready  = !clearing && (count_ff != CNT_W'(QUEUE_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = slot_ff[rd_ptr_ff];
   assign push       = req_valid && req_ready;
   assign pop        = item_pop && item_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule
`default_nettype wire

[rtl/adwu_div.sv]
`default_nettype none
module adwu_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [adwu_pkg::DIV_NUM_W-1:0]  dividend,
   input  logic [adwu_pkg::DIV_DEN_W-1:0]  divisor,
   output logic                            done,
   output logic [adwu_pkg::DIV_NUM_W-1:0]  quotient
);
   import adwu_pkg::*;

   localparam int CNT_W = $clog2(DIV_NUM_W);

   logic [DIV_DEN_W-1:0] rem_ff, rem_in;
   logic [DIV_NUM_W-1:0] quo_ff, quo_in;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_DEN_W:0]   shifted;
   logic                 fits;

   // Restoring division, one quotient bit per cycle.
   always_comb begin
      shifted  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      fits     = (shifted >= {1'b0, den_ff});
      rem_in   = fits ? DIV_DEN_W'(shifted - {1'b0, den_ff}) : shifted[DIV_DEN_W-1:0];
      quo_in   = {quo_ff[DIV_NUM_W-2:0], fits};
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
      end else if (busy_ff) begin
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(DIV_NUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= quo_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule
`default_nettype wire

[rtl/adwu_back.sv]
`default_nettype none
module adwu_back #(
   parameter int unsigned MAX_LENGTH = adwu_pkg::MAX_LENGTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  adwu_pkg::adwu_cfg_type             cfg,
   input  logic                               item_valid,
   input  adwu_pkg::adwu_item_type            item,
   output logic                               item_pop,
   output logic                               clearing,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [adwu_pkg::DATA_W-1:0] rsp_weight,
   output logic [adwu_pkg::INDEX_W-1:0]       rsp_out_index,
   output logic                               rsp_status
);
   import adwu_pkg::*;

   localparam int ADDR_W = (MAX_LENGTH > 1) ? $clog2(MAX_LENGTH) : 1;

   typedef enum logic [13:0] {
      ST_CLEAR  = 14'b00_0000_0000_0001,
      ST_IDLE   = 14'b00_0000_0000_0010,
      ST_READ   = 14'b00_0000_0000_0100,
      ST_MUL1   = 14'b00_0000_0000_1000,
      ST_MUL2   = 14'b00_0000_0001_0000,
      ST_MUL3   = 14'b00_0000_0010_0000,
      ST_MUL4   = 14'b00_0000_0100_0000,
      ST_DIVM   = 14'b00_0000_1000_0000,
      ST_DIVV   = 14'b00_0001_0000_0000,
      ST_SQRT   = 14'b00_0010_0000_0000,
      ST_STEP   = 14'b00_0100_0000_0000,
      ST_DIVQ   = 14'b00_1000_0000_0000,
      ST_UPDATE = 14'b01_0000_0000_0000,
      ST_DONE   = 14'b10_0000_0000_0000
   } back_state_type;

   back_state_type state_ff, state_in;

   adwu_item_type            item_ff;
   logic [ADDR_W-1:0]        addr;
   logic [ADDR_W-1:0]        clr_addr_ff, clr_addr_in;
   logic [COEF_W:0]          bfp_ff, bfp_in;
   logic [COEF_W:0]          bsp_ff, bsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [DATA_W-1:0] rsp_weight_ff;
   logic [INDEX_W-1:0]       rsp_index_ff;
   logic                     rsp_status_ff;
   logic                     slot_free;

   // Datapath registers.
   logic signed [57:0]       prod_a_ff, prod_b_ff;
   logic [63:0]              gsq_ff;
   logic [48:0]              bt_prod1_ff, bt_prod2_ff;
   logic signed [DATA_W-1:0] m_ff;
   logic [30:0]              g2_ff;
   logic [COEF_W:0]          bt1_ff, bt2_ff;
   logic [54:0]              vprod_a_ff;
   logic [55:0]              vprod_b_ff;
   logic [30:0]              v_ff;
   logic                     mh_neg_ff;
   logic [31:0]              mh_mag_ff;
   logic [55:0]              sq_x_ff;
   logic [29:0]              sq_rem_ff;
   logic [27:0]              sq_root_ff;
   logic [4:0]               sq_count_ff;
   logic [33:0]              q_ff;
   logic signed [DATA_W-1:0] res_weight_ff;
   logic                     res_status_ff;

   // Memory ports.
   logic                     mom_wr_en;
   logic [ADDR_W-1:0]        mom_wr_addr;
   logic [DATA_W-1:0]        m_wr_data, v_wr_data;
   logic [DATA_W-1:0]        m_rd_raw, v_rd_raw, w_rd_raw;
   logic signed [DATA_W-1:0] m_rd, w_rd;
   logic                     w_wr_en;
   logic [DATA_W-1:0]        w_wr_data;

   // Divider port.
   logic                     div_start;
   logic [DIV_NUM_W-1:0]     div_num;
   logic [DIV_DEN_W-1:0]     div_den;
   logic                     div_done;
   logic [DIV_NUM_W-1:0]     div_q;

   // Combinational helpers.
   logic signed [COEF_W:0]   b1_s;
   logic signed [COEF_W+1:0] c1_s;
   logic [COEF_W:0]          c2_u;
   logic signed [58:0]       m_sum;
   logic signed [34:0]       m_shift;
   logic signed [DATA_W-1:0] m_sat;
   logic [30:0]              g2_sat;
   logic [56:0]              v_sum;
   logic [30:0]              v_sat;
   logic [31:0]              m_abs;
   logic [COEF_W:0]          d1, d2;
   logic [31:0]              mh_mag;
   logic [30:0]              vh;
   logic [31:0]              sq_shift, sq_trial;
   logic                     sq_fits;
   logic [36:0]              den_sum, den_fix;
   logic [55:0]              mag_prod;
   logic [33:0]              q_cap;
   logic signed [35:0]       nw_sum;
   logic signed [DATA_W-1:0] nw;

   assign addr = ADDR_W'(item_ff.index);
   assign m_rd = $signed(m_rd_raw);
   assign w_rd = $signed(w_rd_raw);

   adwu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH), .ADDR_W(ADDR_W)) u_first_moment (
      .clock   (clock),
      .wr_en   (mom_wr_en),
      .wr_addr (mom_wr_addr),
      .wr_data (m_wr_data),
      .rd_addr (addr),
      .rd_data (m_rd_raw)
   );

   adwu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH), .ADDR_W(ADDR_W)) u_second_moment (
      .clock   (clock),
      .wr_en   (mom_wr_en),
      .wr_addr (mom_wr_addr),
      .wr_data (v_wr_data),
      .rd_addr (addr),
      .rd_data (v_rd_raw)
   );

   adwu_ram #(.WIDTH(DATA_W), .DEPTH(MAX_LENGTH), .ADDR_W(ADDR_W)) u_weights (
      .clock   (clock),
      .wr_en   (w_wr_en),
      .wr_addr (addr),
      .wr_data (w_wr_data),
      .rd_addr (addr),
      .rd_data (w_rd_raw)
   );

   adwu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      b1_s    = $signed({1'b0, cfg.beta_first});
      c1_s    = $signed({1'b0, Q_ONE - {1'b0, cfg.beta_first}});
      c2_u    = Q_ONE - {1'b0, cfg.beta_second};

      // Taking the upper bits of the signed sum is a floor shift.
      m_sum   = prod_a_ff + prod_b_ff;
      m_shift = m_sum[58:24];
      if (m_shift > 35'(SAT_MAX)) begin
         m_sat = SAT_MAX;
      end else if (m_shift < 35'(SAT_MIN)) begin
         m_sat = SAT_MIN;
      end else begin
         m_sat = m_shift[DATA_W-1:0];
      end

      g2_sat  = (|gsq_ff[63:55]) ? 31'h7FFF_FFFF : gsq_ff[54:24];
      v_sum   = vprod_a_ff + vprod_b_ff;
      v_sat   = (|v_sum[56:55]) ? 31'h7FFF_FFFF : v_sum[54:24];

      m_abs   = m_ff[DATA_W-1] ? (~m_ff + 32'd1) : m_ff;
      d1      = Q_ONE - bt1_ff;
      d2      = Q_ONE - bt2_ff;

      if (mh_neg_ff) begin
         mh_mag = ((|div_q[63:32]) || (div_q[31:0] > 32'h8000_0000)) ?
                  32'h8000_0000 : div_q[31:0];
      end else begin
         mh_mag = ((|div_q[63:32]) || div_q[31]) ? 32'h7FFF_FFFF : div_q[31:0];
      end
      vh      = (|div_q[63:31]) ? 31'h7FFF_FFFF : div_q[30:0];

      // One result bit of the square root per cycle.
      sq_shift = {sq_rem_ff, sq_x_ff[55:54]};
      sq_trial = {2'b00, sq_root_ff, 2'b01};
      sq_fits  = (sq_shift >= sq_trial);

      den_sum  = {1'b0, sq_root_ff, 8'h00} + {5'b0, cfg.epsilon_term};
      den_fix  = (den_sum == '0) ? 37'd1 : den_sum;
      mag_prod = mh_mag_ff * cfg.step_size;

      q_cap    = ((|div_q[63:34]) || (div_q[33] && (|div_q[32:0]))) ?
                 34'h2_0000_0000 : div_q[33:0];

      if (mh_neg_ff) begin
         nw_sum = 36'(w_rd) + $signed({2'b00, q_ff});
      end else begin
         nw_sum = 36'(w_rd) - $signed({2'b00, q_ff});
      end
      if (nw_sum > 36'(SAT_MAX)) begin
         nw = SAT_MAX;
      end else if (nw_sum < 36'(SAT_MIN)) begin
         nw = SAT_MIN;
      end else begin
         nw = nw_sum[DATA_W-1:0];
      end
   end

   // Divider requests: bias correction of m, then of v, then the step.
   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '0;
      case (state_ff)
         ST_MUL4: begin
            div_start = 1'b1;
            div_num   = {8'h00, m_abs, 24'h00_0000};
            div_den   = {15'h0000, d1};
         end
         ST_DIVM: begin
            div_start = div_done;
            div_num   = {9'h000, v_ff, 24'h00_0000};
            div_den   = {15'h0000, d2};
         end
         ST_STEP: begin
            div_start = 1'b1;
            div_num   = {mag_prod, 8'h00};
            div_den   = {3'b000, den_fix};
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   // Memory writes.
   always_comb begin
      mom_wr_en   = (state_ff == ST_CLEAR) || (state_ff == ST_UPDATE);
      mom_wr_addr = (state_ff == ST_CLEAR) ? clr_addr_ff : addr;
      m_wr_data   = (state_ff == ST_CLEAR) ? '0 : m_ff;
      v_wr_data   = (state_ff == ST_CLEAR) ? '0 : {1'b0, v_ff};
      w_wr_en     = ((state_ff == ST_READ) && (item_ff.op == OP_LOAD) && !item_ff.bad) ||
                    (state_ff == ST_UPDATE);
      w_wr_data   = (state_ff == ST_UPDATE) ? nw : item_ff.value;
   end

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign item_pop  = (state_ff == ST_IDLE);
   assign clearing  = (state_ff == ST_CLEAR);

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      bfp_in       = bfp_ff;
      bsp_in       = bsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + ADDR_W'(1);
            if (clr_addr_ff == ADDR_W'(MAX_LENGTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (item_valid) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            if (item_ff.bad || (item_ff.op == OP_LOAD)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: state_in = ST_MUL2;
         ST_MUL2: state_in = ST_MUL3;
         ST_MUL3: state_in = ST_MUL4;
         ST_MUL4: state_in = ST_DIVM;
         ST_DIVM: begin
            if (div_done) begin
               state_in = ST_DIVV;
            end
         end
         ST_DIVV: begin
            if (div_done) begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            if (sq_count_ff == 5'd27) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: state_in = ST_DIVQ;
         ST_DIVQ: begin
            if (div_done) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            state_in = ST_DONE;
            if (item_ff.last) begin
               bfp_in = bt1_ff;
               bsp_in = bt2_ff;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_addr_ff  <= '0;
         bfp_ff       <= Q_ONE;
         bsp_ff       <= Q_ONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         bfp_ff       <= bfp_in;
         bsp_ff       <= bsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_ff <= item;
            end
         end
         ST_READ: begin
            res_status_ff <= item_ff.bad;
            res_weight_ff <= item_ff.bad ? '0 : item_ff.value;
         end
         ST_MUL1: begin
            prod_a_ff   <= b1_s * m_rd;
            prod_b_ff   <= c1_s * item_ff.value;
            gsq_ff      <= 64'(item_ff.value * item_ff.value);
            bt_prod1_ff <= bfp_ff * cfg.beta_first;
            bt_prod2_ff <= bsp_ff * cfg.beta_second;
         end
         ST_MUL2: begin
            m_ff   <= m_sat;
            g2_ff  <= g2_sat;
            bt1_ff <= bt_prod1_ff[48:24];
            bt2_ff <= bt_prod2_ff[48:24];
         end
         ST_MUL3: begin
            vprod_a_ff <= cfg.beta_second * v_rd_raw[30:0];
            vprod_b_ff <= c2_u * g2_ff;
         end
         ST_MUL4: begin
            v_ff      <= v_sat;
            mh_neg_ff <= m_ff[DATA_W-1];
         end
         ST_DIVM: begin
            if (div_done) begin
               mh_mag_ff <= mh_mag;
            end
         end
         ST_DIVV: begin
            if (div_done) begin
               sq_x_ff     <= {1'b0, vh, 24'h00_0000};
               sq_rem_ff   <= '0;
               sq_root_ff  <= '0;
               sq_count_ff <= '0;
            end
         end
         ST_SQRT: begin
            sq_x_ff     <= {sq_x_ff[53:0], 2'b00};
            sq_rem_ff   <= sq_fits ? 30'(sq_shift - sq_trial) : sq_shift[29:0];
            sq_root_ff  <= {sq_root_ff[26:0], sq_fits};
            sq_count_ff <= sq_count_ff + 5'd1;
         end
         ST_DIVQ: begin
            if (div_done) begin
               q_ff <= q_cap;
            end
         end
         ST_UPDATE: begin
            res_weight_ff <= nw;
            res_status_ff <= 1'b0;
         end
         ST_DONE: begin
            if (slot_free) begin
               rsp_weight_ff <= res_weight_ff;
               rsp_index_ff  <= item_ff.index;
               rsp_status_ff <= res_status_ff;
            end
         end
         default: begin
            sq_count_ff <= sq_count_ff;
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_weight    = rsp_weight_ff;
   assign rsp_out_index = rsp_index_ff;
   assign rsp_status    = rsp_status_ff;

endmodule
`default_nettype wire

[rtl/adam_weight_update.sv]
// Gradient beat: its result takes three passes through the shared 64-step radix-2
// divider and a pass through the 28-step square root. Load and out-of-range beats
// skip both. One beat is processed at a time; a two-entry queue in front and the
// result register let both sides stall freely.
// Reset: synchronous; afterwards a clearing pass over all MAX_LENGTH addresses zeroes
// the moment memories, during which no beat is accepted.
`default_nettype none
`include "adam_weight_update_defines.svh"
module adam_weight_update #(
   parameter int unsigned MAX_LENGTH = adwu_pkg::MAX_LENGTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [adwu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [adwu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_op,
   input  logic [adwu_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [adwu_pkg::DATA_W-1:0]  req_value,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [adwu_pkg::DATA_W-1:0]  rsp_weight,
   output logic [adwu_pkg::INDEX_W-1:0]        rsp_out_index,
   output logic                                rsp_status
);
   import adwu_pkg::*;

   adwu_cfg_type  cfg_ff, cfg_in;
   adwu_item_type item;
   logic          item_valid;
   logic          item_pop;
   logic          clearing;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_VECTOR_LENGTH: cfg_in.vector_length = csr_wdata[VLEN_W-1:0];
            CSR_STEP_SIZE:     cfg_in.step_size     = csr_wdata[COEF_W-1:0];
            CSR_BETA_FIRST:    cfg_in.beta_first    = csr_wdata[COEF_W-1:0];
            CSR_BETA_SECOND:   cfg_in.beta_second   = csr_wdata[COEF_W-1:0];
            CSR_EPSILON_TERM:  cfg_in.epsilon_term  = csr_wdata[EPS_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.vector_length <= VECTOR_LENGTH_RST;
         cfg_ff.step_size     <= STEP_SIZE_RST;
         cfg_ff.beta_first    <= BETA_FIRST_RST;
         cfg_ff.beta_second   <= BETA_SECOND_RST;
         cfg_ff.epsilon_term  <= EPSILON_TERM_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   adwu_front #(.MAX_LENGTH(MAX_LENGTH)) u_front (
      .clock         (clock),
      .reset         (reset),
      .clearing      (clearing),
      .vector_length (cfg_ff.vector_length),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_op        (req_op),
      .req_index     (req_index),
      .req_value     (req_value),
      .req_last      (req_last),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop)
   );

   adwu_back #(.MAX_LENGTH(MAX_LENGTH)) u_back (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg_ff),
      .item_valid    (item_valid),
      .item          (item),
      .item_pop      (item_pop),
      .clearing      (clearing),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_weight    (rsp_weight),
      .rsp_out_index (rsp_out_index),
      .rsp_status    (rsp_status)
   );

   // No beat enters and no result leaves while the moments are being cleared.
   `AWU_ASSERT_NOW(a_clear_quiet, clock, reset, clearing, !req_ready && !rsp_valid)
   // A rejected index always comes back with a zero weight.
   `AWU_ASSERT_NOW(a_bad_zero, clock, reset, rsp_valid && rsp_status, rsp_weight == '0)
   // An accepted result refers to an index inside the active vector.
   `AWU_ASSERT_NOW(a_ok_in_range, clock, reset, rsp_valid && !rsp_status,
                   {1'b0, rsp_out_index} < cfg_ff.vector_length)

endmodule
`default_nettype wire

[bench/adam_weight_update_checker.sv]
`timescale 1ns / 100ps
module adam_weight_update_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [adwu_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [adwu_pkg::CSR_DATA_W-1:0]     csr_wdata,
   input  logic                                req_valid,
   input  logic                                req_ready,
   input  logic                                req_op,
   input  logic [adwu_pkg::INDEX_W-1:0]        req_index,
   input  logic signed [adwu_pkg::DATA_W-1:0]  req_value,
   input  logic                                req_last,
   input  logic                                rsp_valid,
   input  logic                                rsp_ready,
   input  logic signed [adwu_pkg::DATA_W-1:0]  rsp_weight,
   input  logic [adwu_pkg::INDEX_W-1:0]        rsp_out_index,
   input  logic                                rsp_status,
   output int                                  failures,
   output int                                  pending
);
   import adwu_pkg::*;

   localparam logic signed [63:0] ONE_Q24 = 64'sd16777216;

   typedef struct packed {
      logic signed [DATA_W-1:0] weight;
      logic [INDEX_W-1:0]       out_index;
      logic                     status;
   } update_result_type;

   update_result_type weight_updates[$];

   adwu_cfg_type             cfg;
   logic signed [DATA_W-1:0] moment_one[MAX_LENGTH_DEF];
   logic signed [DATA_W-1:0] moment_two[MAX_LENGTH_DEF];
   logic signed [DATA_W-1:0] weight_mem[MAX_LENGTH_DEF];
   logic [COEF_W:0]          power_one;
   logic [COEF_W:0]          power_two;

   function automatic logic signed [63:0] saturate(logic signed [63:0] x);
      if (x > 64'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
      if (x < -64'sh8000_0000) return -64'sh8000_0000;
      return x;
   endfunction

   // Floor square root by building the result one bit at a time.
   function automatic logic [63:0] floor_root(logic [63:0] x);
      logic [63:0] acc;
      logic [63:0] trial;
      acc = 0;
      for (int i = 29; i >= 0; i--) begin
         trial = acc | (64'd1 << i);
         if (trial * trial <= x) acc = trial;
      end
      return acc;
   endfunction

   function automatic update_result_type adam_step(logic op, logic [INDEX_W-1:0] idx,
                                                   logic signed [DATA_W-1:0] value,
                                                   logic last);
      update_result_type res;
      int unsigned       limit;
      logic signed [63:0] b1, b2, g, m, v, g2, mh, vh, d1, d2, nw;
      logic [63:0]        bt1, bt2, root, den, mag, q;
      limit = (cfg.vector_length < MAX_LENGTH_DEF) ? cfg.vector_length : MAX_LENGTH_DEF;
      res.out_index = idx;
      if (idx >= limit) begin
         res.weight = '0;
         res.status = 1'b1;
         return res;
      end
      res.status = 1'b0;
      if (op == OP_LOAD) begin
         weight_mem[idx] = value;
         res.weight = value;
         return res;
      end
      g  = value;
      b1 = {40'd0, cfg.beta_first};
      b2 = {40'd0, cfg.beta_second};
      m  = saturate((b1 * moment_one[idx] + (ONE_Q24 - b1) * g) >>> 24);
      g2 = (g * g) >>> 24;
      if (g2 > 64'sh7FFF_FFFF) g2 = 64'sh7FFF_FFFF;
      v  = (b2 * moment_two[idx] + (ONE_Q24 - b2) * g2) >>> 24;
      if (v > 64'sh7FFF_FFFF) v = 64'sh7FFF_FFFF;
      bt1 = ({39'd0, power_one} * {40'd0, cfg.beta_first}) >> 24;
      bt2 = ({39'd0, power_two} * {40'd0, cfg.beta_second}) >> 24;
      d1  = ONE_Q24 - $signed(bt1);
      d2  = ONE_Q24 - $signed(bt2);
      mh  = saturate((m * ONE_Q24) / d1);
      vh  = (v * ONE_Q24) / d2;
      if (vh > 64'sh7FFF_FFFF) vh = 64'sh7FFF_FFFF;
      root = floor_root(vh << 24);
      den  = (root << 8) + {32'd0, cfg.epsilon_term};
      if (den == 0) den = 1;
      mag = (mh < 0 ? -mh : mh) * {40'd0, cfg.step_size};
      q   = (mag << 8) / den;
      if (q > (64'd1 << 33)) q = 64'd1 << 33;
      nw = saturate(weight_mem[idx] - (mh < 0 ? -$signed(q) : $signed(q)));
      moment_one[idx] = m[31:0];
      moment_two[idx] = v[31:0];
      weight_mem[idx] = nw[31:0];
      if (last) begin
         power_one = bt1[COEF_W:0];
         power_two = bt2[COEF_W:0];
      end
      res.weight = nw[31:0];
      return res;
   endfunction

   int mismatches = 0;
   assign failures = mismatches;
   assign pending  = weight_updates.size();

   always @(posedge clock) begin
      update_result_type got;
      update_result_type want;
      if (reset) begin
         cfg <= {VECTOR_LENGTH_RST, STEP_SIZE_RST, BETA_FIRST_RST, BETA_SECOND_RST,
                 EPSILON_TERM_RST};
         for (int i = 0; i < MAX_LENGTH_DEF; i++) begin
            moment_one[i] = '0;
            moment_two[i] = '0;
         end
         power_one = Q_ONE;
         power_two = Q_ONE;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_VECTOR_LENGTH: cfg.vector_length <= csr_wdata[VLEN_W-1:0];
               CSR_STEP_SIZE:     cfg.step_size     <= csr_wdata[COEF_W-1:0];
               CSR_BETA_FIRST:    cfg.beta_first    <= csr_wdata[COEF_W-1:0];
               CSR_BETA_SECOND:   cfg.beta_second   <= csr_wdata[COEF_W-1:0];
               CSR_EPSILON_TERM:  cfg.epsilon_term  <= csr_wdata[EPS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            weight_updates.push_back(adam_step(req_op, req_index, req_value, req_last));
         if (rsp_valid && rsp_ready) begin
            got = {rsp_weight, rsp_out_index, rsp_status};
            if (weight_updates.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Unexpected result beat: weight %h index %0d status %0d",
                           got.weight, got.out_index, got.status);
            end else begin
               want = weight_updates.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected weight %h index %0d status %0d, got %h %0d %0d",
                              want.weight, want.out_index, want.status,
                              got.weight, got.out_index, got.status);
               end
            end
         end
      end
   end
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps
module tb;
   import adwu_pkg::*;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_op = 1'b0;
   logic [INDEX_W-1:0]       req_index = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     req_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [DATA_W-1:0] rsp_weight;
   logic [INDEX_W-1:0]       rsp_out_index;
   logic                     rsp_status;
   int                       failures;
   int                       pending;

   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   bit  stall_request = 0;
   bit  stall_taken = 0;
   int  hold_left = 0;
   int  index_limit = MAX_LENGTH_DEF;
   bit  is_loaded[MAX_LENGTH_DEF];
   int  loaded_list[$];

   adam_weight_update DUT (.*);

   adam_weight_update_checker checker_inst (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #6_000_000;
      $display("FAIL");
      $finish;
   end

   // The receiver owns its long hold-off so the block backs up into its input queue.
   always @(posedge clock) begin
      if (stall_request && !stall_taken) begin
         stall_taken <= 1;
         hold_left   <= 3000;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   task automatic send_beat(logic op, int idx, logic [31:0] val, logic last);
      bit hit;
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_index <= idx[INDEX_W-1:0];
      req_value <= val;
      req_last  <= last;
      if (op == OP_LOAD && idx < index_limit && !is_loaded[idx]) begin
         is_loaded[idx] = 1;
         loaded_list.push_back(idx);
      end
      do begin
         @(negedge clock);
         hit = req_ready;
         @(posedge clock);
      end while (!hit);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (5) @(posedge clock);
   endtask

   task automatic write_config(int unsigned vlen, int unsigned rate, int unsigned b1,
                               int unsigned b2, int unsigned eps);
      logic [31:0] vals[5];
      vals = '{vlen, rate, b1, b2, eps};
      for (int i = 0; i < 5; i++) begin
         csr_wr_en <= 1'b1;
         csr_index <= i[CSR_INDEX_W-1:0];
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
      index_limit = (vlen[10:0] < MAX_LENGTH_DEF) ? vlen[10:0] : MAX_LENGTH_DEF;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return 32'h0;
         3, 4: return $urandom;
         default: return $signed($urandom) >>> $urandom_range(4, 24);
      endcase
   endfunction

   // Mostly gradients on loaded slots, with some loads and some out-of-range noise.
   task automatic random_beat();
      int  roll;
      int  cand;
      bit  ok;
      roll = $urandom_range(0, 99);
      ok   = 0;
      cand = 0;
      if (index_limit == 0 || (roll < 8 && index_limit < MAX_LENGTH_DEF)) begin
         send_beat($urandom_range(0, 1), $urandom_range(index_limit, MAX_LENGTH_DEF - 1),
                   pick_value(), $urandom_range(0, 1));
         return;
      end
      for (int t = 0; t < 4 && !ok && loaded_list.size() > 0; t++) begin
         cand = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
         ok   = (cand < index_limit);
      end
      if (roll < 25 || !ok)
         send_beat(OP_LOAD, $urandom_range(0, index_limit - 1), pick_value(),
                   $urandom_range(0, 1));
      else
         send_beat(OP_GRADIENT, cand, pick_value(), ($urandom_range(0, 7) == 0));
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, both operations, index limits and denominators.
      send_beat(OP_LOAD, 0, 32'h7FFF_FFFF, 1'b1);
      send_beat(OP_LOAD, 1023, 32'h8000_0000, 1'b0);
      send_beat(OP_LOAD, 5, 32'h0, 1'b0);
      send_beat(OP_GRADIENT, 0, 32'h7FFF_FFFF, 1'b0);
      send_beat(OP_GRADIENT, 1023, 32'h8000_0000, 1'b0);
      send_beat(OP_GRADIENT, 5, 32'h0, 1'b1);
      send_beat(OP_GRADIENT, 0, 32'hFFFF_FFFF, 1'b1);
      drain();
      write_config(8, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0);
      send_beat(OP_LOAD, 8, 32'h1234_5678, 1'b0);
      send_beat(OP_GRADIENT, 1023, 32'h0100_0000, 1'b1);
      send_beat(OP_LOAD, 7, 32'h0000_0001, 1'b0);
      // Zero gradient on fresh moments with no epsilon forces the minimum denominator.
      send_beat(OP_GRADIENT, 7, 32'h0, 1'b0);
      send_beat(OP_GRADIENT, 7, 32'h0000_0001, 1'b1);
      send_beat(OP_GRADIENT, 5, 32'hFF00_0000, 1'b0);
      drain();
      write_config(0, 0, 0, 0, 32'hFFFF_FFFF);
      send_beat(OP_LOAD, 0, 32'h5555_5555, 1'b0);
      send_beat(OP_GRADIENT, 0, 32'h0100_0000, 1'b1);
      drain();
      write_config(2047, 1, 0, 0, 32'hFFFF_FFFF);
      send_beat(OP_GRADIENT, 1023, 32'h7FFF_FFFF, 1'b1);
      send_beat(OP_LOAD, 1000, 32'hAAAA_AAAA, 1'b1);
      send_beat(OP_GRADIENT, 1000, 32'h8000_0000, 1'b0);
      drain();

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_config(64, 16777, 15099494, 16760439, 43);
            1: write_config($urandom_range(1, 1024), $urandom_range(0, 24'hFF_FFFF),
                            $urandom_range(0, 24'hFF_FFFF), $urandom_range(0, 24'hFF_FFFF),
                            $urandom);
            2: write_config(1, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF, 0);
            3: write_config(1500, 1, 0, 0, 32'hFFFF_FFFF);
            default: write_config($urandom_range(16, 200), $urandom_range(0, 24'hFF_FFFF),
                                  $urandom_range(0, 24'hFF_FFFF),
                                  $urandom_range(0, 24'hFF_FFFF), $urandom);
         endcase
         tx_idle_pct = (phase < 2) ? 23 : (phase < 4) ? 65 : 0;
         rx_idle_pct = (phase < 2) ? 65 : (phase < 4) ? 23 : 0;
         for (int n = 0; n < 310; n++) begin
            if (phase == 4 && n == 20) stall_request = 1;
            random_beat();
         end
         drain();
      end

      repeat (300) @(posedge clock);
      if (failures == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end
endmodule
